// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hdl/stt_pkg.sv =====
`timescale 1ns / 1ps

package stt_pkg;

  localparam int MAX_SOURCE_BYTES = 65536;
  localparam int KEYWORD_CHARS_DEF = 9;

  localparam logic [15:0] OFFSET_CAP =
    ((MAX_SOURCE_BYTES - 1) < 65535) ? 16'(MAX_SOURCE_BYTES - 1) : 16'hFFFF;
  localparam logic [15:0] LINE_CAP = 16'hFFFF;

  localparam int RES_MAX = 3;

  localparam logic [4:0] K_EOF      = 5'd0;
  localparam logic [4:0] K_IDENT    = 5'd1;
  localparam logic [4:0] K_NUMBER   = 5'd2;
  localparam logic [4:0] K_KW_FIRST = 5'd3;
  localparam logic [4:0] K_LPAREN   = 5'd12;
  localparam logic [4:0] K_RPAREN   = 5'd13;
  localparam logic [4:0] K_LBRACE   = 5'd14;
  localparam logic [4:0] K_RBRACE   = 5'd15;
  localparam logic [4:0] K_SEMI     = 5'd16;
  localparam logic [4:0] K_COMMA    = 5'd17;
  localparam logic [4:0] K_ASSIGN   = 5'd18;
  localparam logic [4:0] K_PLUS     = 5'd19;
  localparam logic [4:0] K_MINUS    = 5'd20;
  localparam logic [4:0] K_STAR     = 5'd21;
  localparam logic [4:0] K_SLASH    = 5'd22;
  localparam logic [4:0] K_INVALID  = 5'd23;

  localparam int KW_COUNT   = 9;
  localparam int KW_MAX_LEN = 9;

  // Keyword text is right-aligned: the last character sits in the low byte.
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    72'("void"), 72'("float"), 72'("vec2"), 72'("vec3"), 72'("vec4"),
    72'("sampler2D"), 72'("attribute"), 72'("uniform"), 72'("varying")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd4, 4'd9, 4'd9, 4'd7, 4'd7
  };

  typedef struct packed {
    logic [7:0] source_byte;
    logic       byte_present;
    logic       end_of_source;
  } stt_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic        last_in_run;
  } stt_tok_t;

  typedef struct packed {
    logic [1:0]                count;
    stt_tok_t [RES_MAX-1:0]    tok;
  } stt_grp_t;

endpackage

// ===== hdl/stt_kw_match.sv =====
`timescale 1ns / 1ps

module stt_kw_match import stt_pkg::*; (
  input  logic [KW_MAX_LEN-1:0][7:0] ch,
  input  logic [15:0]                len,
  output logic [4:0]                 kind
);

  logic [KW_COUNT-1:0] hit;

  always_comb begin
    hit = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit[i] = (len == 16'(KW_LEN[i]));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < int'(KW_LEN[i])) begin
          if (ch[j] != KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8]) begin
            hit[i] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    kind = K_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        kind = K_KW_FIRST + 5'(i);
      end
    end
  end

endmodule

// ===== hdl/stt_lexer.sv =====
`timescale 1ns / 1ps

module stt_lexer import stt_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  stt_in_t  item,
  output stt_grp_t grp
);

  localparam int KW_IDX_W = $clog2(KEYWORD_CHARS);

  localparam logic [2:0] M_IDLE      = 3'd0;
  localparam logic [2:0] M_IDENT     = 3'd1;
  localparam logic [2:0] M_NUMBER    = 3'd2;
  localparam logic [2:0] M_EXPWAIT   = 3'd3;
  localparam logic [2:0] M_SIGNWAIT  = 3'd4;
  localparam logic [2:0] M_SLASHWAIT = 3'd5;
  localparam logic [2:0] M_COMMENT   = 3'd6;

  logic [2:0]  mode;
  logic [15:0] off;
  logic [15:0] line;
  logic [15:0] so;
  logic [15:0] sl;
  logic        dot;
  logic        exp_seen;
  logic [7:0]  kw [KEYWORD_CHARS];

  logic [2:0]  mode_next;
  logic [15:0] off_next;
  logic [15:0] line_next;
  logic [15:0] so_next;
  logic [15:0] sl_next;
  logic        dot_next;
  logic        exp_next;

  logic [2:0]  p_mode;
  logic [15:0] p_off;
  logic [15:0] p_line;
  logic [15:0] p_so;
  logic [15:0] p_sl;
  logic        p_dot;
  logic        p_exp;

  logic                kw_we;
  logic [KW_IDX_W-1:0] kw_idx;
  logic                absorbed;

  logic [7:0]  c;
  logic [15:0] len;
  logic [15:0] len2;
  logic [15:0] line_inc;
  logic [15:0] off_inc;
  logic [4:0]  kind1;
  logic [4:0]  kind2;

  logic [KW_MAX_LEN-1:0][7:0] kw_cur;
  logic [KW_MAX_LEN-1:0][7:0] kw_view;

  stt_tok_t [1:0] cand_byte;
  logic     [1:0] cand_byte_v;
  stt_tok_t [1:0] cand_end;
  logic     [1:0] cand_end_v;
  stt_tok_t [3:0] cand;
  logic     [3:0] cand_v;
  logic     [2:0] n;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {["a":"z"], ["A":"Z"], "_"});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {["0":"9"]});
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      "=": k = K_ASSIGN;
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  function automatic logic has_pending(input logic [2:0] m);
    return (m inside {M_IDENT, M_NUMBER, M_EXPWAIT, M_SIGNWAIT, M_SLASHWAIT});
  endfunction

  function automatic stt_tok_t pending_tok(input logic [2:0] m, input logic [4:0] ik,
                                           input logic [15:0] s, input logic [15:0] l,
                                           input logic [15:0] ln);
    stt_tok_t t;
    t.token_start  = s;
    t.token_length = l;
    t.token_line   = ln;
    t.last_in_run  = 1'b0;
    case (m)
      M_IDENT:     t.token_kind = ik;
      M_NUMBER:    t.token_kind = K_NUMBER;
      M_SLASHWAIT: begin
        t.token_kind   = K_SLASH;
        t.token_length = 16'd1;
      end
      default:     t.token_kind = K_INVALID;
    endcase
    return t;
  endfunction

  assign c        = item.source_byte;
  assign len      = off - so;
  assign len2     = p_off - p_so;
  assign line_inc = (line < LINE_CAP) ? line + 16'd1 : line;
  assign off_inc  = (off < OFFSET_CAP) ? off + 16'd1 : off;

  assign cand   = {cand_end, cand_byte};
  assign cand_v = {cand_end_v, cand_byte_v};

  always_comb begin
    for (int j = 0; j < KW_MAX_LEN; j++) begin
      kw_cur[j]  = kw[j];
      kw_view[j] = (kw_we && kw_idx == KW_IDX_W'(j)) ? c : kw[j];
    end
  end

  stt_kw_match u_kw_cur (
    .ch   (kw_cur),
    .len  (len),
    .kind (kind1)
  );

  stt_kw_match u_kw_end (
    .ch   (kw_view),
    .len  (len2),
    .kind (kind2)
  );

  // Byte step: extend the pending token, or close it and handle this byte on its own.
  always_comb begin
    p_mode   = mode;
    p_off    = off;
    p_line   = line;
    p_so     = so;
    p_sl     = sl;
    p_dot    = dot;
    p_exp    = exp_seen;
    kw_we    = 1'b0;
    kw_idx   = '0;
    absorbed = 1'b0;
    cand_byte[0] = pending_tok(mode, kind1, so, len, sl);
    cand_byte[1] = '{token_kind: punct_kind(c), token_start: off, token_length: 16'd1,
                     token_line: line, last_in_run: 1'b0};
    cand_byte_v  = 2'b00;
    if (item.byte_present) begin
      case (mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            absorbed = 1'b1;
            if (len < 16'(KEYWORD_CHARS)) begin
              kw_we  = 1'b1;
              kw_idx = len[KW_IDX_W-1:0];
            end
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            absorbed = 1'b1;
          end else if (c == "." && !dot) begin
            absorbed = 1'b1;
            p_dot    = 1'b1;
          end else if ((c == "e" || c == "E") && !exp_seen) begin
            absorbed = 1'b1;
            p_exp    = 1'b1;
            p_mode   = M_EXPWAIT;
          end
        end
        M_EXPWAIT: begin
          if (c == "+" || c == "-") begin
            absorbed = 1'b1;
            p_mode   = M_SIGNWAIT;
          end else if (is_digit(c)) begin
            absorbed = 1'b1;
            p_mode   = M_NUMBER;
          end
        end
        M_SIGNWAIT: begin
          if (is_digit(c)) begin
            absorbed = 1'b1;
            p_mode   = M_NUMBER;
          end
        end
        M_SLASHWAIT: begin
          if (c == "/") begin
            absorbed = 1'b1;
            p_mode   = M_COMMENT;
          end
        end
        M_COMMENT: begin
          absorbed = 1'b1;
          if (c == 8'h0A) begin
            p_mode = M_IDLE;
            p_line = line_inc;
          end
        end
        default: absorbed = 1'b0;
      endcase
      if (!absorbed) begin
        cand_byte_v[0] = has_pending(mode);
        p_mode         = M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0D) begin
          p_mode = M_IDLE;
        end else if (c == 8'h0A) begin
          p_line = line_inc;
        end else if (is_alpha(c)) begin
          p_so   = off;
          p_sl   = line;
          kw_we  = 1'b1;
          kw_idx = '0;
          p_mode = M_IDENT;
        end else if (is_digit(c) || c == ".") begin
          p_so   = off;
          p_sl   = line;
          p_dot  = (c == ".");
          p_exp  = 1'b0;
          p_mode = M_NUMBER;
        end else if (c == "/") begin
          p_so   = off;
          p_sl   = line;
          p_mode = M_SLASHWAIT;
        end else begin
          cand_byte_v[1] = 1'b1;
        end
      end
      p_off = off_inc;
    end
  end

  // End marker: close what is pending, add the EOF token and start over.
  always_comb begin
    mode_next = p_mode;
    off_next  = p_off;
    line_next = p_line;
    so_next   = p_so;
    sl_next   = p_sl;
    dot_next  = p_dot;
    exp_next  = p_exp;
    cand_end[0] = pending_tok(p_mode, kind2, p_so, len2, p_sl);
    cand_end[1] = '{token_kind: K_EOF, token_start: p_off, token_length: 16'd0,
                    token_line: p_line, last_in_run: 1'b0};
    cand_end_v  = 2'b00;
    if (item.end_of_source) begin
      cand_end_v[0] = has_pending(p_mode);
      cand_end_v[1] = 1'b1;
      mode_next = M_IDLE;
      off_next  = 16'd0;
      line_next = 16'd1;
      so_next   = 16'd0;
      sl_next   = 16'd1;
      dot_next  = 1'b0;
      exp_next  = 1'b0;
    end
  end

  always_comb begin
    n       = 3'd0;
    grp.tok = '0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k] && n < 3'(RES_MAX)) begin
        grp.tok[n[1:0]] = cand[k];
        n = n + 3'd1;
      end
    end
    if (n != 3'd0) begin
      grp.tok[2'(n - 3'd1)].last_in_run = 1'b1;
    end
    grp.count = n[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      off      <= 16'd0;
      line     <= 16'd1;
      so       <= 16'd0;
      sl       <= 16'd1;
      dot      <= 1'b0;
      exp_seen <= 1'b0;
    end else if (fire) begin
      mode     <= mode_next;
      off      <= off_next;
      line     <= line_next;
      so       <= so_next;
      sl       <= sl_next;
      dot      <= dot_next;
      exp_seen <= exp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && kw_we) begin
      kw[kw_idx] <= c;
    end
  end

endmodule

// ===== hdl/stt_result_buf.sv =====
`timescale 1ns / 1ps

module stt_result_buf import stt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  stt_grp_t grp,
  output logic     ready,
  output logic     tok_valid,
  input  logic     tok_stall,
  output stt_tok_t tok_item
);

  stt_tok_t   res [RES_MAX];
  logic [1:0] count;
  logic       taken;

  assign tok_valid = (count != 2'd0);
  assign tok_item  = res[0];
  assign taken     = tok_valid && !tok_stall;
  assign ready     = (count == 2'd0) || (count == 2'd1 && taken);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= grp.count;
    end else if (taken) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < RES_MAX; k++) begin
        res[k] <= grp.tok[k];
      end
    end else if (taken) begin
      for (int k = 0; k < RES_MAX - 1; k++) begin
        res[k] <= res[k + 1];
      end
    end
  end

endmodule

// ===== hdl/shader_source_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// src      in         src_valid / src_stall  src_item (one source byte or end marker)
// tok      out        tok_valid / tok_stall  tok_item (one token)
//
// An item is registered on acceptance and lexed, once the result register is ready, into up to
// three tokens, which land in the result register; the first token is visible once they are loaded.
// One item is taken per cycle while each item yields at most one token and tok_stall is low;
// an item that yields k tokens holds the result register for k output transactions.
// Synchronous reset returns the lexer to the start of a new source, line 1, offset 0.
// A stall on the token channel backs up through the input register to src_stall.

module shader_source_tokenizer_top import stt_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  stt_in_t  src_item,
  output logic     tok_valid,
  input  logic     tok_stall,
  output stt_tok_t tok_item
);

  logic     in_valid;
  stt_in_t  in_item;
  logic     buf_ready;
  logic     fire;
  stt_grp_t grp;

  assign fire      = in_valid && buf_ready;
  assign src_stall = in_valid && !buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!src_stall) begin
      in_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall && src_valid) begin
      in_item <= src_item;
    end
  end

  stt_lexer #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_lexer (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .grp  (grp)
  );

  stt_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .grp       (grp),
    .ready     (buf_ready),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
  );

endmodule

// ===== hdl/stt_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_checker import stt_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     src_stall,
  input logic     tok_valid,
  input logic     tok_stall,
  input stt_tok_t tok_item
);

  logic tok_held;
  logic is_eof;

  assign tok_held = tok_valid && tok_stall;
  assign is_eof   = tok_valid && tok_item.token_kind == K_EOF;

  `ASSERT_NEXT(a_tok_valid_held, clk, rst, tok_held, tok_valid)
  `ASSERT_NEXT(a_tok_item_held, clk, rst, tok_held, $stable(tok_item))
  `ASSERT_IMPL(a_eof_closes_run, clk, rst, is_eof, tok_item.last_in_run)
  `ASSERT_IMPL(a_stall_needs_token, clk, rst, src_stall, tok_valid)
  `ASSERT_IMPL(a_line_nonzero, clk, rst, tok_valid, tok_item.token_line != 16'd0)

endmodule

bind shader_source_tokenizer_top stt_checker u_stt_checker (.*);
